### rtl/pswt_pkg.sv
package pswt_pkg;

    // Default sizing of the string table
    localparam int MAX_TABLE_LEN_DEF = 2048;
    localparam int MIN_TABLE_LEN_DEF = 64;

    // Field widths
    localparam int TL_W       = 12;
    localparam int INC_W      = 19;
    localparam int AMP_W      = 16;
    localparam int IDX_W      = 12;
    localparam int SMP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Datapath widths: entry difference, interpolated value (Q1.23), scaled product
    localparam int DIFF_W   = SMP_W + 1;
    localparam int INTERP_W = 25;
    localparam int MULB_W   = AMP_W + 1;
    localparam int PROD_W   = INTERP_W + MULB_W;
    localparam int RND_SHIFT = 23;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE       = 2'd2;

    // Register reset values
    localparam logic [TL_W-1:0]  TABLE_LENGTH_RST    = 12'd64;
    localparam logic [INC_W-1:0] PHASE_INCREMENT_RST = 19'd256;
    localparam logic [AMP_W-1:0] AMPLITUDE_RST       = 16'd16384;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_DIFF,
        ST_SCALE,
        ST_OUT,
        ST_WRAP0,
        ST_WRAP1,
        ST_WRAP2,
        ST_SMOOTH
    } state_t;

    // Shared multiplier operand select
    typedef enum logic {
        MUL_INTERP,
        MUL_SCALE
    } mul_sel_t;

    typedef struct packed {
        logic     en;
        mul_sel_t sel;
    } mul_ctrl_t;

endpackage

### rtl/pswt_mul_unit.sv
module pswt_mul_unit (
    input  logic                                clk,
    input  pswt_pkg::mul_ctrl_t                 ctrl,
    input  logic signed [pswt_pkg::DIFF_W-1:0]   diff,
    input  logic        [7:0]                    frac,
    input  logic signed [pswt_pkg::INTERP_W-1:0] interp,
    input  logic        [pswt_pkg::AMP_W-1:0]    amp,
    output logic signed [pswt_pkg::PROD_W-1:0]   prod
);

    logic signed [pswt_pkg::INTERP_W-1:0] mul_a;
    logic signed [pswt_pkg::MULB_W-1:0]   mul_b;
    logic signed [pswt_pkg::PROD_W-1:0]   prod_reg;

    // Operand select: slope times fraction, or interpolated value times gain
    always_comb
    begin
        unique case (ctrl.sel)
            pswt_pkg::MUL_INTERP:
            begin
                mul_a = pswt_pkg::INTERP_W'(diff);
                mul_b = {{(pswt_pkg::MULB_W - 8){1'b0}}, frac};
            end
            default:
            begin
                mul_a = interp;
                mul_b = {1'b0, amp};
            end
        endcase
    end

    // Registered product
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= pswt_pkg::PROD_W'(mul_a) * pswt_pkg::PROD_W'(mul_b);
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/plucked_string_wavetable.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    operation, load_index, load_value
// out      out_valid / out_ready  sample
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load is written as it is accepted; a tick is paced by the single read port of
// the string table and the one shared multiplier used twice per sample.
// A tick whose phase wraps then runs a smoothing pass that reads each entry
// through that port and rewrites it once.
// After reset the table is cleared one entry per cycle, all MAX_TABLE_LEN + 1 entries
// (2049 by default), during which in_ready stays low; cfg writes are always taken.
// A tick holds in its output step while the output register is still occupied.
module plucked_string_wavetable #(
    parameter int MAX_TABLE_LEN = pswt_pkg::MAX_TABLE_LEN_DEF,
    parameter int MIN_TABLE_LEN = pswt_pkg::MIN_TABLE_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic        [pswt_pkg::IDX_W-1:0]    load_index,
    input  logic signed [pswt_pkg::SMP_W-1:0]    load_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pswt_pkg::SMP_W-1:0]    sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [pswt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [pswt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_TABLE_LEN + 1;
    localparam int ADDR_W = $clog2(MAX_TABLE_LEN + 1);
    localparam int SPAN_W = ADDR_W + 8;
    localparam int LW     = (ADDR_W > pswt_pkg::TL_W) ? ADDR_W : pswt_pkg::TL_W;
    localparam int CW     = (SPAN_W > pswt_pkg::INC_W) ? SPAN_W : pswt_pkg::INC_W;
    localparam int SW     = pswt_pkg::SMP_W;
    localparam int RND_W  = pswt_pkg::PROD_W - pswt_pkg::RND_SHIFT;

    // Configuration registers
    logic [pswt_pkg::TL_W-1:0]  table_length_reg;
    logic [pswt_pkg::INC_W-1:0] phase_increment_reg;
    logic [pswt_pkg::AMP_W-1:0] amplitude_reg;

    // Control and datapath registers
    pswt_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [SPAN_W-1:0]       phase_reg, phase_next;
    logic signed [SW-1:0]    e0_reg, e0_next;
    logic signed [SW-1:0]    prev_reg, prev_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    sample_reg, sample_next;

    // String table
    logic signed [SW-1:0]    mem [DEPTH];
    logic signed [SW-1:0]    rd_data_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [SW-1:0]    mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;

    // Derived values
    logic [LW-1:0]           len_ext;
    logic [ADDR_W-1:0]       len_eff;
    logic [SPAN_W-1:0]       span;
    logic [CW-1:0]           inc_ext;
    logic [CW-1:0]           span_m1_ext;
    logic [SPAN_W-1:0]       inc_eff;
    logic [SPAN_W:0]         phase_sum;
    logic                    phase_wrap;
    logic [ADDR_W-1:0]       phase_k;
    logic                    in_acc;
    logic                    load_ok;
    logic                    out_load;
    logic signed [pswt_pkg::DIFF_W-1:0]   diff;
    logic signed [pswt_pkg::INTERP_W-1:0] interp;
    logic signed [pswt_pkg::PROD_W-1:0]   prod;
    logic signed [pswt_pkg::PROD_W-1:0]   prod_rnd;
    logic signed [RND_W-1:0]              prod_sh;
    logic signed [SW-1:0]                 sample_sat;
    logic signed [SW:0]                   smooth_sum;
    pswt_pkg::mul_ctrl_t                  mul_ctrl;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == pswt_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Active length, phase span and clamped increment
    always_comb
    begin
        len_ext = LW'(table_length_reg);
        if (len_ext < LW'(MIN_TABLE_LEN))
        begin
            len_ext = LW'(MIN_TABLE_LEN);
        end
        if (len_ext > LW'(MAX_TABLE_LEN))
        begin
            len_ext = LW'(MAX_TABLE_LEN);
        end
        len_eff     = ADDR_W'(len_ext);
        span        = {len_eff, 8'd0};
        inc_ext     = CW'(phase_increment_reg);
        span_m1_ext = CW'(span - SPAN_W'(1));
        if (inc_ext > span_m1_ext)
        begin
            inc_eff = span - SPAN_W'(1);
        end
        else
        begin
            inc_eff = SPAN_W'(inc_ext);
        end
    end

    assign phase_sum  = {1'b0, phase_reg} + {1'b0, inc_eff};
    assign phase_wrap = (phase_sum >= {1'b0, span});
    assign phase_k    = ADDR_W'(phase_reg >> 8);
    assign load_ok    = (LW'(load_index) <= LW'(MAX_TABLE_LEN));
    assign out_load   = (state_reg == pswt_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    // Interpolation and output rounding
    assign diff       = pswt_pkg::DIFF_W'(rd_data_reg) - pswt_pkg::DIFF_W'(e0_reg);
    assign interp     = (pswt_pkg::INTERP_W'(e0_reg) <<< 8) + pswt_pkg::INTERP_W'(prod);
    assign prod_rnd   = prod + (pswt_pkg::PROD_W'(1) <<< (pswt_pkg::RND_SHIFT - 1));
    assign prod_sh    = prod_rnd[pswt_pkg::PROD_W-1:pswt_pkg::RND_SHIFT];
    assign smooth_sum = (SW + 1)'(rd_data_reg) + (SW + 1)'(prev_reg);

    always_comb
    begin
        if (prod_sh > RND_W'(signed'(17'sd32767)))
        begin
            sample_sat = 16'sh7FFF;
        end
        else if (prod_sh < RND_W'(signed'(-17'sd32768)))
        begin
            sample_sat = -16'sh8000;
        end
        else
        begin
            sample_sat = SW'(prod_sh);
        end
    end

    pswt_mul_unit u_mul (
        .clk    (clk),
        .ctrl   (mul_ctrl),
        .diff   (diff),
        .frac   (phase_reg[7:0]),
        .interp (interp),
        .amp    (amplitude_reg),
        .prod   (prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pswt_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MAX_TABLE_LEN))
                begin
                    state_next = pswt_pkg::ST_IDLE;
                end
            end
            pswt_pkg::ST_IDLE:
            begin
                if (in_acc && operation == pswt_pkg::OP_TICK)
                begin
                    state_next = pswt_pkg::ST_RD0;
                end
            end
            pswt_pkg::ST_RD0:   state_next = pswt_pkg::ST_RD1;
            pswt_pkg::ST_RD1:   state_next = pswt_pkg::ST_DIFF;
            pswt_pkg::ST_DIFF:  state_next = pswt_pkg::ST_SCALE;
            pswt_pkg::ST_SCALE: state_next = pswt_pkg::ST_OUT;
            pswt_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = phase_wrap ? pswt_pkg::ST_WRAP0 : pswt_pkg::ST_IDLE;
                end
            end
            pswt_pkg::ST_WRAP0: state_next = pswt_pkg::ST_WRAP1;
            pswt_pkg::ST_WRAP1: state_next = pswt_pkg::ST_WRAP2;
            pswt_pkg::ST_WRAP2: state_next = pswt_pkg::ST_SMOOTH;
            pswt_pkg::ST_SMOOTH:
            begin
                if (idx_reg == len_eff)
                begin
                    state_next = pswt_pkg::ST_IDLE;
                end
            end
            default:            state_next = pswt_pkg::ST_CLEAR;
        endcase
    end

    // Sequencer outputs: table port, multiplier control, datapath updates
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = '0;
        mem_raddr      = phase_k;
        mul_ctrl.en    = 1'b0;
        mul_ctrl.sel   = pswt_pkg::MUL_INTERP;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        e0_next        = e0_reg;
        prev_next      = prev_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            pswt_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            pswt_pkg::ST_IDLE:
            begin
                if (in_acc && operation == pswt_pkg::OP_LOAD && load_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(load_index);
                    mem_wdata = load_value;
                end
                // a phase left past a shortened table restarts at zero
                if (in_acc && operation == pswt_pkg::OP_TICK && phase_reg >= span)
                begin
                    phase_next = '0;
                end
            end
            pswt_pkg::ST_RD0:
            begin
                mem_raddr = phase_k;
            end
            pswt_pkg::ST_RD1:
            begin
                mem_raddr = phase_k + ADDR_W'(1);
                e0_next   = rd_data_reg;
            end
            pswt_pkg::ST_DIFF:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = pswt_pkg::MUL_INTERP;
            end
            pswt_pkg::ST_SCALE:
            begin
                mul_ctrl.en  = 1'b1;
                mul_ctrl.sel = pswt_pkg::MUL_SCALE;
            end
            pswt_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sample_sat;
                    phase_next     = phase_wrap ? SPAN_W'(phase_sum - {1'b0, span})
                                                : SPAN_W'(phase_sum);
                end
            end
            pswt_pkg::ST_WRAP0:
            begin
                mem_raddr = '0;
            end
            pswt_pkg::ST_WRAP1:
            begin
                mem_raddr = len_eff;
                prev_next = rd_data_reg;
            end
            pswt_pkg::ST_WRAP2:
            begin
                // guard entry moves to the head
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = rd_data_reg;
                mem_raddr = ADDR_W'(1);
                idx_next  = ADDR_W'(1);
            end
            pswt_pkg::ST_SMOOTH:
            begin
                // running two-point average, floor of half the sum
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = SW'(smooth_sum >>> 1);
                prev_next = SW'(smooth_sum >>> 1);
                mem_raddr = (idx_reg == len_eff) ? idx_reg : idx_reg + ADDR_W'(1);
                idx_next  = idx_reg + ADDR_W'(1);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= pswt_pkg::ST_CLEAR;
            clr_addr_reg        <= '0;
            phase_reg           <= '0;
            out_valid_reg       <= 1'b0;
            table_length_reg    <= pswt_pkg::TABLE_LENGTH_RST;
            phase_increment_reg <= pswt_pkg::PHASE_INCREMENT_RST;
            amplitude_reg       <= pswt_pkg::AMPLITUDE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pswt_pkg::CFG_TABLE_LENGTH:
                        table_length_reg <= cfg_data[pswt_pkg::TL_W-1:0];
                    pswt_pkg::CFG_PHASE_INCREMENT:
                        phase_increment_reg <= cfg_data[pswt_pkg::INC_W-1:0];
                    pswt_pkg::CFG_AMPLITUDE:
                        amplitude_reg <= cfg_data[pswt_pkg::AMP_W-1:0];
                    default:
                        amplitude_reg <= amplitude_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        e0_reg     <= e0_next;
        prev_reg   <= prev_next;
        sample_reg <= sample_next;
    end

    // A tick keeps the input closed while it works
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == pswt_pkg::OP_TICK) |=> !in_ready)
        else $error("input open right after a tick");

    // Smoothing walks entries 1 to the active length only
    a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pswt_pkg::ST_SMOOTH) |-> (idx_reg != '0 && idx_reg <= len_eff))
        else $error("smoothing index out of range");

    // After a sample is issued the phase lies inside the span
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (phase_reg < span))
        else $error("phase not wrapped");

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = pswt_pkg::MAX_TABLE_LEN_DEF + 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 255;
    localparam int REPORT_LIMIT   = 10;
    // index with no register behind it
    localparam logic [pswt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic                              op;
        logic [pswt_pkg::IDX_W-1:0]        idx;
        logic signed [pswt_pkg::SMP_W-1:0] val;
    } voice_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = pswt_pkg::OP_LOAD;
    logic [pswt_pkg::IDX_W-1:0] load_index = '0;
    logic signed [pswt_pkg::SMP_W-1:0] load_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [pswt_pkg::SMP_W-1:0] sample;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pswt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pswt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // voice model state
    logic signed [pswt_pkg::SMP_W-1:0] string_mem [0:pswt_pkg::MAX_TABLE_LEN_DEF];
    int unsigned                       voice_phase;
    logic [pswt_pkg::TL_W-1:0]         tl_reg;
    logic [pswt_pkg::INC_W-1:0]        inc_reg;
    logic [pswt_pkg::AMP_W-1:0]        amp_reg;

    voice_item_t                       pending_items[$];
    logic signed [pswt_pkg::SMP_W-1:0] expected_samples[$];
    int                                items_outstanding = 0;

    int err_cnt = 0;
    int n_loads = 0;
    int n_ticks = 0;
    int n_wraps = 0;
    int n_samples = 0;
    int n_cfg = 0;
    int n_settings = 0;

    plucked_string_wavetable dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .load_index (load_index),
        .load_value (load_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned active_len(input logic [pswt_pkg::TL_W-1:0] tl);
        if (tl < pswt_pkg::MIN_TABLE_LEN_DEF)
            return pswt_pkg::MIN_TABLE_LEN_DEF;
        if (tl > pswt_pkg::MAX_TABLE_LEN_DEF)
            return pswt_pkg::MAX_TABLE_LEN_DEF;
        return tl;
    endfunction

    // One input transaction through the voice: returns the sample a tick gives
    function automatic void advance_voice(input voice_item_t it, output bit produced,
                                          output logic signed [pswt_pkg::SMP_W-1:0] smp);
        int unsigned len;
        int unsigned span;
        int unsigned step;
        int unsigned k;
        longint      frac;
        longint      e0;
        longint      e1;
        longint      v;
        longint      prod;
        int          prev;
        produced = 1'b0;
        smp = '0;
        if (it.op == pswt_pkg::OP_LOAD)
        begin
            n_loads++;
            if (it.idx <= pswt_pkg::MAX_TABLE_LEN_DEF)
                string_mem[it.idx] = it.val;
            return;
        end
        n_ticks++;
        len = active_len(tl_reg);
        span = len << 8;
        step = (inc_reg > span - 1) ? span - 1 : inc_reg;
        // phase left past the end by a shorter table restarts at zero
        if (voice_phase >= span)
            voice_phase = 0;

        // linear interpolation, then gain with round-half-up and saturation
        k = voice_phase >> 8;
        frac = longint'(voice_phase & 255);
        e0 = longint'(string_mem[k]);
        e1 = longint'(string_mem[k + 1]);
        v = e0 * 256 + (e1 - e0) * frac;
        prod = (v * longint'(amp_reg) + (64'sd1 <<< (pswt_pkg::RND_SHIFT - 1)))
               >>> pswt_pkg::RND_SHIFT;
        if (prod > 32767)
            prod = 32767;
        if (prod < -32768)
            prod = -32768;
        smp = prod[pswt_pkg::SMP_W-1:0];
        produced = 1'b1;

        // wrap: guard entry to the front, then average down the table
        voice_phase += step;
        if (voice_phase >= span)
        begin
            n_wraps++;
            voice_phase -= span;
            prev = string_mem[0];
            string_mem[0] = string_mem[len];
            for (int i = 1; i <= len; i++)
            begin
                prev = (int'(string_mem[i]) + prev) >>> 1;
                string_mem[i] = prev[pswt_pkg::SMP_W-1:0];
            end
        end
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic queue_item(input logic op, input logic [pswt_pkg::IDX_W-1:0] idx,
                              input logic signed [pswt_pkg::SMP_W-1:0] val);
        voice_item_t it;
        it.op = op;
        it.idx = idx;
        it.val = val;
        pending_items.push_back(it);
        items_outstanding++;
    endtask

    // Register write; valid stays high so writes can go back to back
    task automatic cfg_write(input logic [pswt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pswt_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        n_cfg++;
        case (idx)
            pswt_pkg::CFG_TABLE_LENGTH:    tl_reg = data[pswt_pkg::TL_W-1:0];
            pswt_pkg::CFG_PHASE_INCREMENT: inc_reg = data[pswt_pkg::INC_W-1:0];
            pswt_pkg::CFG_AMPLITUDE:       amp_reg = data[pswt_pkg::AMP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_voice(input logic [pswt_pkg::CFG_DATA_W-1:0] tl_data,
                                 input logic [pswt_pkg::CFG_DATA_W-1:0] inc_data,
                                 input logic [pswt_pkg::CFG_DATA_W-1:0] amp_data,
                                 input bit poke_unused);
        n_settings++;
        cfg_write(pswt_pkg::CFG_TABLE_LENGTH, tl_data);
        if (poke_unused)
            cfg_write(CFG_UNUSED, pswt_pkg::CFG_DATA_W'($urandom));
        cfg_write(pswt_pkg::CFG_PHASE_INCREMENT, inc_data);
        cfg_write(pswt_pkg::CFG_AMPLITUDE, amp_data);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every transaction and sample, then for a full smoothing pass
    task automatic settle();
        while (items_outstanding != 0 || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver
    voice_item_t cur_item;
    int          in_gap;
    bit          in_burst = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        bit                                produced;
        logic signed [pswt_pkg::SMP_W-1:0] smp;
        int                                draw;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (in_valid && in_ready)
        begin
            advance_voice(cur_item, produced, smp);
            if (produced)
                expected_samples.push_back(smp);
            items_outstanding--;
            draw = in_burst ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                in_burst = !in_burst;
            if (draw == 0 && pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                operation  <= cur_item.op;
                load_index <= cur_item.idx;
                load_value <= cur_item.val;
            end
            else
            begin
                in_valid <= 1'b0;
                in_gap = (draw > 0) ? draw - 1 : 0;
            end
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                in_valid   <= 1'b1;
                operation  <= cur_item.op;
                load_index <= cur_item.idx;
                load_value <= cur_item.val;
            end
        end
    end

    // Output monitor and checker
    int out_hold;
    bit out_burst = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [pswt_pkg::SMP_W-1:0] want;
        int                                stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold = 0;
        end
        else if (out_valid && out_ready)
        begin
            n_samples++;
            if (expected_samples.size() == 0)
                flag_error($sformatf("sample %0d arrived with nothing expected", sample));
            else
            begin
                want = expected_samples.pop_front();
                if (sample !== want)
                    flag_error($sformatf("sample %0d: expected %0d, got %0d",
                                         n_samples, want, sample));
            end
            stall = out_burst ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                out_burst = !out_burst;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                out_hold = stall - 1;
            end
        end
        else if (!out_ready)
        begin
            if (out_hold > 0)
                out_hold--;
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned len;
        int unsigned span;
        int          tl;
        int          amp;
        int          r;
        int          n;
        int          random_items;
        logic [pswt_pkg::CFG_DATA_W-1:0] inc_data;
        logic signed [pswt_pkg::SMP_W-1:0] val;

        for (int i = 0; i <= pswt_pkg::MAX_TABLE_LEN_DEF; i++)
            string_mem[i] = '0;
        voice_phase = 0;
        tl_reg  = pswt_pkg::TABLE_LENGTH_RST;
        inc_reg = pswt_pkg::PHASE_INCREMENT_RST;
        amp_reg = pswt_pkg::AMPLITUDE_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shortest table with masked upper bits, increment clamped, gain above unity
        program_voice({7'h7F, 12'd64}, 19'h7FFFF, 19'h7FFFF, 1'b1);
        queue_item(pswt_pkg::OP_LOAD, 12'd0, 16'sh7FFF);
        queue_item(pswt_pkg::OP_LOAD, 12'd1, -16'sh8000);
        queue_item(pswt_pkg::OP_LOAD, 12'd63, -16'sh8000);
        queue_item(pswt_pkg::OP_LOAD, 12'd64, 16'sh7FFF);
        queue_item(pswt_pkg::OP_LOAD, 12'd2048, -16'sh8000);
        queue_item(pswt_pkg::OP_LOAD, 12'd4095, 16'sh7FFF);     // past the guard: dropped
        queue_item(pswt_pkg::OP_LOAD, 12'd2049, 16'sd1);        // past the guard: dropped
        queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        queue_item(pswt_pkg::OP_TICK, 12'hFFF, -16'sd1);        // crosses the end, smoothed
        queue_item(pswt_pkg::OP_LOAD, 12'd5, -16'sd1);
        queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        settle();

        // Longest table, large step so the phase lands far into it
        program_voice(19'h00FFF, 19'd300000, 19'd32768, 1'b0);
        queue_item(pswt_pkg::OP_LOAD, 12'd1000, 16'sd20000);
        queue_item(pswt_pkg::OP_LOAD, 12'd1171, -16'sd20000);
        for (int i = 0; i < 5; i++)
            queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        settle();

        // Table shrunk below the phase, zero step and zero gain
        program_voice(19'h7F000, 19'd0, 19'd0, 1'b0);
        queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        queue_item(pswt_pkg::OP_LOAD, 12'd3, 16'sd1234);
        queue_item(pswt_pkg::OP_TICK, 12'd0, 16'sd0);
        settle();

        // Random settings, each followed by a mix of loads and ticks
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                tl = $urandom_range(64, 160);
            else if (r < 70)
                tl = $urandom_range(0, 63);
            else if (r < 90)
                tl = $urandom_range(161, 2047);
            else
                tl = $urandom_range(2048, 4095);
            len = active_len(tl[pswt_pkg::TL_W-1:0]);
            span = len << 8;

            case ($urandom_range(0, 4))
                0:       inc_data = pswt_pkg::CFG_DATA_W'($urandom_range(0, 512));
                1, 2:    inc_data = pswt_pkg::CFG_DATA_W'($urandom_range(0, span - 1));
                3:       inc_data = pswt_pkg::CFG_DATA_W'($urandom_range(span - 64, span + 64));
                default: inc_data = pswt_pkg::CFG_DATA_W'($urandom);
            endcase

            r = $urandom_range(0, 99);
            if (r < 50)
                amp = $urandom_range(0, 32768);
            else if (r < 70)
            begin
                case ($urandom_range(0, 2))
                    0:       amp = 0;
                    1:       amp = 32768;
                    default: amp = 65535;
                endcase
            end
            else
                amp = $urandom_range(0, 65535);

            program_voice({7'($urandom), 12'(tl)}, inc_data, {3'($urandom), 16'(amp)},
                          $urandom_range(0, 3) == 0);

            n = $urandom_range(25, 45);
            for (int j = 0; j < n; j++)
            begin
                val = pswt_pkg::SMP_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    val = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                if ($urandom_range(0, 99) < 35)
                begin
                    if ($urandom_range(0, 3) != 0)
                        queue_item(pswt_pkg::OP_LOAD,
                                   pswt_pkg::IDX_W'($urandom_range(0, len)), val);
                    else
                        queue_item(pswt_pkg::OP_LOAD, pswt_pkg::IDX_W'($urandom), val);
                end
                else
                    queue_item(pswt_pkg::OP_TICK, pswt_pkg::IDX_W'($urandom), val);
            end
            random_items += n;
            settle();
        end

        if (expected_samples.size() != 0)
            flag_error($sformatf("%0d samples never arrived", expected_samples.size()));
        $display("run: %0d loads, %0d ticks, %0d samples compared, %0d table wraps",
                 n_loads, n_ticks, n_samples, n_wraps);
        $display("run: %0d register writes over %0d settings, %0d errors",
                 n_cfg, n_settings, err_cnt);
        if (err_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/pswt_pkg.sv
rtl/pswt_mul_unit.sv
rtl/plucked_string_wavetable.sv
bench/testbench.sv
